[rtl/core/dtpb_pkg.sv]
// Shared widths, register codes and reset values for the depth back-projection block.
package dtpb_pkg;

	localparam int DEPTH_W        = 16;
	localparam int POS_W          = 12;
	localparam int FOCAL_W        = 15;
	localparam int CENTER_W       = 12;
	localparam int POINT_W        = 16;
	localparam int COORD_BITS_DEF = 12;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

	localparam logic [FOCAL_W-1:0]  FOCAL_X_RST  = 15'd931;
	localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST  = 15'd931;
	localparam logic [CENTER_W-1:0] CENTER_X_RST = 12'd965;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST = 12'd548;

endpackage

[rtl/core/dtpb_axis.sv]
// One axis datapath: offset, exact product, magnitude and a bit-per-stage divider.
module dtpb_axis #(
	parameter int POS_BITS = 12
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [dtpb_pkg::DEPTH_W-1:0]      depth,
	input  logic [dtpb_pkg::POS_W-1:0]        pos,
	input  logic [dtpb_pkg::CENTER_W-1:0]     center,
	input  logic [dtpb_pkg::FOCAL_W-1:0]      focal,
	output logic [dtpb_pkg::POINT_W-1:0]      point
);
	import dtpb_pkg::*;

	// quotient magnitude bits, and signed product width
	localparam int QB = DEPTH_W + POS_BITS;
	localparam int PW = QB + 1;

	// s1: offset from principal point
	logic [DEPTH_W-1:0]      depth_s1;
	logic signed [POS_BITS:0] diff_s1;
	// s2: exact signed product
	logic signed [PW-1:0]    prod_s2;
	// s3 feeds the divider: sign and magnitude
	logic signed [PW:0]      prod_full;
	logic [PW-1:0]           prod_neg;
	logic [QB-1:0]           mag;
	// divider stages, index 0 is loaded by s3
	logic [FOCAL_W-1:0]      div_rem_s [0:QB];
	logic [QB-1:0]           div_dq_s  [0:QB];
	logic                    div_neg_s [0:QB];
	// s4: signed, wrapped result
	logic [QB-1:0]           quo_neg;
	logic [QB-1:0]           quo_res;
	logic [POINT_W-1:0]      point_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			depth_s1 <= depth;
			diff_s1  <= $signed({1'b0, pos[POS_BITS-1:0]}) - $signed({1'b0, center[POS_BITS-1:0]});
		end
	end

	assign prod_full = (PW+1)'($signed({1'b0, depth_s1})) * (PW+1)'(diff_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_full[PW-1:0];
		end
	end

	assign prod_neg = -prod_s2;
	assign mag      = prod_s2[PW-1] ? prod_neg[QB-1:0] : prod_s2[QB-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s[0] <= '0;
			div_dq_s[0]  <= mag;
			div_neg_s[0] <= prod_s2[PW-1];
		end
	end

	// restoring division; the dividend shifts out the top while quotient bits fill the bottom
	for (genvar i = 0; i < QB; i++) begin : g_div
		logic [FOCAL_W:0] trial;
		logic [FOCAL_W:0] sub;
		logic             ge;

		assign trial = {div_rem_s[i], div_dq_s[i][QB-1]};
		assign sub   = trial - {1'b0, focal};
		assign ge    = trial >= {1'b0, focal};

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[i+1] <= ge ? sub[FOCAL_W-1:0] : trial[FOCAL_W-1:0];
				div_dq_s[i+1]  <= {div_dq_s[i][QB-2:0], ge};
				div_neg_s[i+1] <= div_neg_s[i];
			end
		end
	end

	assign quo_neg = ~div_dq_s[QB] + {{(QB-1){1'b0}}, 1'b1};
	assign quo_res = div_neg_s[QB] ? quo_neg : div_dq_s[QB];

	// zero focal length forces a zero coordinate
	always_ff @(posedge clk) begin
		if (en) begin
			point_s4 <= (focal == '0) ? '0 : quo_res[POINT_W-1:0];
		end
	end

	assign point = point_s4;

endmodule

[rtl/core/depth_to_point_backprojection.sv]
// Top level: pinhole back-projection of a depth pixel stream to x, y, z points.
//
//  channel | dir | width | contents
//  s_*     | in  | 40    | depth, column, row
//  m_*     | out | 48    | point_x, point_y, point_z
//  cfg_*   | in  | 2/15  | focal_x, focal_y, center_x, center_y
//
// One word per clock in and out when unstalled. The pipeline registers are: offset,
// product, magnitude, one stage per quotient bit of the divider (16 + min(COORD_BITS, 12)
// stages), result, output register.
// Reset loads the register defaults and clears all valid bits; payload is not reset.
// A one-word skid behind the output register lets the pipeline drain one word into
// it under back-pressure; s_tready drops only while the skid is occupied.
module depth_to_point_backprojection #(
	parameter int COORD_BITS = dtpb_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dtpb_pkg::IN_DATA_W-1:0]    s_tdata,  // depth[15:0], column[27:16], row[39:28]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [dtpb_pkg::OUT_DATA_W-1:0]   m_tdata,  // point_x[15:0], point_y[31:16], point_z[47:32]
	input  logic                              cfg_we,
	input  logic [dtpb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dtpb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dtpb_pkg::*;

	// coordinates arrive on 12-bit fields, so masking wider than that changes nothing
	localparam int EFF_BITS = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
	localparam int QB       = DEPTH_W + EFF_BITS;
	// offset, product, magnitude, divider stages, result
	localparam int NSTG     = QB + 4;

	logic [FOCAL_W-1:0]  focal_x_q, focal_y_q;
	logic [CENTER_W-1:0] center_x_q, center_y_q;

	logic                adv;
	logic                v_s [0:NSTG-1];
	logic [DEPTH_W-1:0]  z_s [0:NSTG-1];
	logic [POINT_W-1:0]  px, py;
	logic [OUT_DATA_W-1:0] pipe_word;
	logic                v_last;

	logic                  out_v_q, skid_v_q;
	logic [OUT_DATA_W-1:0] out_data_q, skid_data_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOCAL_X:  focal_x_q  <= cfg_data;
				REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				REG_CENTER_X: center_x_q <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves together unless the skid is holding a word
	assign adv      = !skid_v_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s[0] <= s_tdata[15:0];
		end
	end

	for (genvar k = 1; k < NSTG; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				z_s[k] <= z_s[k-1];
			end
		end
	end

	dtpb_axis #(.POS_BITS(EFF_BITS)) u_axis_x (
		.clk    (clk),
		.en     (adv),
		.depth  (s_tdata[15:0]),
		.pos    (s_tdata[27:16]),
		.center (center_x_q),
		.focal  (focal_x_q),
		.point  (px)
	);

	dtpb_axis #(.POS_BITS(EFF_BITS)) u_axis_y (
		.clk    (clk),
		.en     (adv),
		.depth  (s_tdata[15:0]),
		.pos    (s_tdata[39:28]),
		.center (center_y_q),
		.focal  (focal_y_q),
		.point  (py)
	);

	assign v_last    = v_s[NSTG-1];
	assign pipe_word = {z_s[NSTG-1], py, px};

	// output register with one-word skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q  <= skid_v_q || v_last;
			skid_v_q <= 1'b0;
		end else if (v_last && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_data_q <= skid_v_q ? skid_data_q : pipe_word;
		end else if (v_last && !skid_v_q) begin
			skid_data_q <= pipe_word;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

	// skid fills only behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a word while output register is empty");

	// a finished word meeting a stalled output goes to the skid
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready && v_last && !skid_v_q) |=> skid_v_q)
		else $error("finished word not caught by skid");

	// skid drains in order into the output register
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && m_tready && skid_v_q) |=> (m_tvalid && m_tdata == $past(skid_data_q)))
		else $error("skid word not forwarded to output");

endmodule

[tb/tb_depth_to_point_backprojection.sv]
// Self-checking testbench for the depth-pixel to x/y/z point back-projection block.
`timescale 1ns / 1ps

module tb_depth_to_point_backprojection;

	import dtpb_pkg::*;

	// Timeout in clock cycles. The slowest run is about 1200 words, each with idle
	// gaps on the sender and stalls on the receiver, plus the pipeline latency and
	// one long hold-off. This is several times that.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 40;    // pipeline latency plus margin
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int PHASE_WORDS   = 128;
	localparam int PHASE_COUNT   = 9;
	localparam int DIRECTED_ROWS = 18;

	// one back-projected point, point_x first
	typedef struct packed {
		logic [POINT_W-1:0] px;
		logic [POINT_W-1:0] py;
		logic [POINT_W-1:0] pz;
	} point_t;

	// directed stimulus row; fixed = 1 means the expected point is typed in
	typedef struct packed {
		logic               fixed;
		logic [DEPTH_W-1:0] depth;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		point_t             want;
	} pixel_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;  // depth[15:0], column[27:16], row[39:28]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // point_x[15:0], point_y[31:16], point_z[47:32]
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow copy of the camera registers, updated on every write
	logic [FOCAL_W-1:0]  cam_focal_x;
	logic [FOCAL_W-1:0]  cam_focal_y;
	logic [CENTER_W-1:0] cam_center_x;
	logic [CENTER_W-1:0] cam_center_y;

	point_t pending_points[$];  // predicted points, oldest first
	int     err_count;
	int     cycle_count;
	int     hold_req;           // set by the sender, served by the receiver
	bit     send_idle;
	bit     recv_idle;

	// Directed rows, run with the reset camera (f = 931, cx = 965, cy = 548).
	// Typed rows: zero depth, pixel on the principal point, one-pixel offsets
	// around it, and a unit depth far off-center. The rest go to the predictor:
	// full-scale depth at the image corners (quotient wraps), bit patterns and mixed values.
	pixel_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{1'b1, 16'd0,     12'd0,    12'd0,    '{16'd0,     16'd0,     16'd0}},
		'{1'b1, 16'd0,     12'd4095, 12'd4095, '{16'd0,     16'd0,     16'd0}},
		'{1'b1, 16'd65535, 12'd965,  12'd548,  '{16'd0,     16'd0,     16'd65535}},
		'{1'b1, 16'd1,     12'd965,  12'd548,  '{16'd0,     16'd0,     16'd1}},
		'{1'b1, 16'd931,   12'd966,  12'd549,  '{16'd1,     16'd1,     16'd931}},
		'{1'b1, 16'd931,   12'd964,  12'd547,  '{16'hFFFF,  16'hFFFF,  16'd931}},
		'{1'b1, 16'd1,     12'd0,    12'd4095, '{16'hFFFF,  16'd3,     16'd1}},
		'{1'b0, 16'd65535, 12'd0,    12'd0,    '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'd65535, 12'd4095, 12'd4095, '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'd65535, 12'd0,    12'd4095, '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'd65535, 12'd4095, 12'd0,    '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'h8000,  12'h800,  12'h800,  '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'h5555,  12'h555,  12'hAAA,  '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'hAAAA,  12'hAAA,  12'h555,  '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'h0001,  12'h001,  12'h001,  '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'h7FFF,  12'h7FF,  12'h7FF,  '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'd1000,  12'd1930, 12'd1479, '{16'd0,     16'd0,     16'd0}},
		'{1'b0, 16'd12345, 12'd17,   12'd3000, '{16'd0,     16'd0,     16'd0}}
	};

	depth_to_point_backprojection uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20 ns clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// depth * (pos - center) / focal, truncated toward zero, low 16 bits kept;
	// a zero focal length gives zero
	function automatic logic [POINT_W-1:0] backproject_axis(
		input logic [DEPTH_W-1:0]  depth,
		input logic [POS_W-1:0]    pos,
		input logic [CENTER_W-1:0] center,
		input logic [FOCAL_W-1:0]  focal
	);
		longint offset;
		longint prod;
		longint quot;
		if (focal == '0)
			return '0;
		offset = longint'(pos) - longint'(center);
		prod   = longint'(depth) * offset;
		quot   = prod / longint'(focal);
		return quot[POINT_W-1:0];
	endfunction

	function automatic point_t backproject_pixel(
		input logic [DEPTH_W-1:0] depth,
		input logic [POS_W-1:0]   col,
		input logic [POS_W-1:0]   row
	);
		point_t pt;
		pt.px = backproject_axis(depth, col, cam_center_x, cam_focal_x);
		pt.py = backproject_axis(depth, row, cam_center_y, cam_focal_y);
		pt.pz = depth;
		return pt;
	endfunction

	// coordinates lean toward the image edges
	function automatic logic [POS_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic [DEPTH_W-1:0] rand_depth();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return DEPTH_W'($urandom_range(0, 15));
			default: return DEPTH_W'($urandom);
		endcase
	endfunction

	// register write; register bits above each width are dropped in the shadow
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
		case (idx)
			REG_FOCAL_X:  cam_focal_x  = val[FOCAL_W-1:0];
			REG_FOCAL_Y:  cam_focal_y  = val[FOCAL_W-1:0];
			REG_CENTER_X: cam_center_x = val[CENTER_W-1:0];
			REG_CENTER_Y: cam_center_y = val[CENTER_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_camera(
		input logic [CFG_DATA_W-1:0] fx, input logic [CFG_DATA_W-1:0] fy,
		input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy
	);
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
	endtask

	// Offer one pixel word and hold it until accepted. Called at a falling edge,
	// returns at the falling edge after the handshake. The expectation is queued
	// at offer time; the word cannot come out before it is accepted.
	task automatic send_pixel(
		input logic [DEPTH_W-1:0] depth,
		input logic [POS_W-1:0]   col,
		input logic [POS_W-1:0]   row,
		input point_t             want
	);
		int gap;
		gap = send_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pending_points.push_back(want);
		s_tvalid = 1'b1;
		s_tdata  = {row, col, depth};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// config writes only once the pipeline holds nothing
	task automatic wait_idle();
		wait (pending_points.size() == 0);
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		logic [DEPTH_W-1:0] d;
		logic [POS_W-1:0]   c;
		logic [POS_W-1:0]   r;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		arst_n       = 1'b0;
		err_count    = 0;
		hold_req     = 0;
		send_idle    = 1'b1;
		recv_idle    = 1'b1;
		cam_focal_x  = FOCAL_X_RST;
		cam_focal_y  = FOCAL_Y_RST;
		cam_center_x = CENTER_X_RST;
		cam_center_y = CENTER_Y_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, reset camera
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].fixed)
				send_pixel(directed_rows[i].depth, directed_rows[i].col,
					directed_rows[i].row, directed_rows[i].want);
			else
				send_pixel(directed_rows[i].depth, directed_rows[i].col,
					directed_rows[i].row,
					backproject_pixel(directed_rows[i].depth, directed_rows[i].col,
						directed_rows[i].row));
		end

		// random part, one camera setting per phase
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			s_tvalid = 1'b0;
			wait_idle();
			send_idle = 1'b1;
			recv_idle = 1'b1;
			case (ph)
				// unit focal length: quotients far beyond 16 bits, keep low bits
				0: write_camera(15'd1, 15'd1, 15'd0, 15'd4095);
				// largest focal length, centers at the opposite corner; no idling
				1: begin
					write_camera(15'd32767, 15'd32767, 15'd4095, 15'd0);
					send_idle = 1'b0;
					recv_idle = 1'b0;
				end
				// zero focal length gives zero; center bits above 12 are dropped
				2: write_camera(15'd0, 15'd0, 15'h7FFF, 15'h4123);
				// zero focal length on one axis only
				3: write_camera(15'd0, 15'd7, 15'd2048, 15'd2047);
				// small focal lengths, random centers
				4, 5: write_camera(15'($urandom_range(1, 2000)), 15'($urandom_range(1, 2000)),
					15'($urandom), 15'($urandom));
				// any value the port can carry
				6: write_camera(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
				7: write_camera(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
					15'($urandom_range(0, 4095)), 15'($urandom_range(0, 4095)));
				// back to the power-on camera
				default: write_camera(FOCAL_X_RST, FOCAL_Y_RST, 15'(CENTER_X_RST),
					15'(CENTER_Y_RST));
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// long receiver hold-off while words keep coming at full rate:
				// the pipeline and skid fill and s_tready drops
				if (ph == 4 && n == 10) begin
					hold_req  = HOLD_CYCLES;
					send_idle = 1'b0;
				end
				if (ph == 4 && n == 90)
					send_idle = 1'b1;
				d = rand_depth();
				c = rand_coord();
				r = rand_coord();
				send_pixel(d, c, r, backproject_pixel(d, c, r));
			end
		end
		s_tvalid = 1'b0;

		// drain, then watch a while for stray words
		wait (pending_points.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stall per word, plus the long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req > 0) begin
				m_tready = 1'b0;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
			end
			stall = recv_idle ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// check each accepted output word against the oldest prediction
	always @(posedge clk) begin
		point_t want;
		point_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]};
			if (pending_points.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				err_count++;
			end else begin
				want = pending_points.pop_front();
				if (got.px !== want.px) begin
					$error("point_x mismatch: expected %0d, got %0d",
						$signed(want.px), $signed(got.px));
					err_count++;
				end
				if (got.py !== want.py) begin
					$error("point_y mismatch: expected %0d, got %0d",
						$signed(want.py), $signed(got.py));
					err_count++;
				end
				if (got.pz !== want.pz) begin
					$error("point_z mismatch: expected %0d, got %0d", want.pz, got.pz);
					err_count++;
				end
			end
		end
	end

	initial cycle_count = 0;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// timeout
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
